// File: rtl/handle_pool_allocator_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef HANDLE_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define HANDLE_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define HPA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define HPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/hpa_pkg.sv
package hpa_pkg;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_TRY   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fq_ctrl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_fq_stat;

endpackage

// File: rtl/handle_pool_allocator_unit.sv
// Result: registered as the EXEC state completes; EXEC waits while a stalled
// result is held. No new transaction is taken until EXEC is done: IDLE does the
// read of the in-use bitmap and free-queue memories, EXEC the modify and write-back.
// Reset: synchronous, active low; clears queue pointers, fresh counter and
// handshake state. No clearing pass: bitmap entries at or above the fresh
// counter read as free.
module handle_pool_allocator_unit import hpa_pkg::*; #(
    parameter int HANDLES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_release_handle,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_granted_handle,
    output logic [1:0] o_status
);

    localparam int HW = $clog2(HANDLES);
    localparam int CW = $clog2(HANDLES + 1);
    localparam int EW = (CW > 8) ? CW : 8;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_EXEC = 1'b1;

    logic [0:0]    r_state, n_state;
    logic [CW-1:0] r_fresh, n_fresh;
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_granted, n_granted;
    logic [1:0]    r_status, n_status;
    logic [1:0]    r_op;
    logic [7:0]    r_rel;

    logic          map_mem [HANDLES];
    logic          r_map_rd;
    logic [HW-1:0] map_rd_addr;
    logic          map_we;
    logic [HW-1:0] map_wr_addr;
    logic          map_wr_data;

    t_fq_ctrl      fq_ctrl;
    t_fq_stat      fq_stat;
    logic [HW-1:0] fq_rd_data;

    logic          in_acc;
    logic          done;
    logic          rel_in_use;
    logic          fresh_exhausted;
    logic [EW-1:0] rel_ext;
    logic [EW-1:0] fresh_ext;

    hpa_free_queue #(
        .HANDLES (HANDLES)
    ) u_free_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (fq_ctrl),
        .i_push_data (HW'(r_rel)),
        .o_rd_data   (fq_rd_data),
        .o_stat      (fq_stat)
    );

    assign rel_ext         = EW'(r_rel);
    assign fresh_ext       = EW'(r_fresh);
    assign rel_in_use      = (rel_ext < fresh_ext) && r_map_rd;
    assign fresh_exhausted = (r_fresh == CW'(HANDLES));
    assign map_rd_addr     = (r_state == S_IDLE) ? HW'(i_release_handle) : HW'(r_rel);

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign done       = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_fresh     = r_fresh;
        n_out_valid = r_out_valid && i_out_stall;
        n_granted   = r_granted;
        n_status    = r_status;
        map_we      = 1'b0;
        map_wr_addr = HW'(r_rel);
        map_wr_data = 1'b0;
        fq_ctrl     = '0;
        if (in_acc) begin
            n_state = S_EXEC;
        end
        if (done) begin
            n_state     = S_IDLE;
            n_out_valid = 1'b1;
            n_granted   = '0;
            n_status    = ST_OK;
            unique case (r_op)
                OP_ALLOC, OP_TRY: begin
                    priority if (!fq_stat.empty) begin
                        fq_ctrl.pop = 1'b1;
                        map_we      = 1'b1;
                        map_wr_addr = fq_rd_data;
                        map_wr_data = 1'b1;
                        n_granted   = 8'(fq_rd_data);
                    end else if (r_op == OP_TRY) begin
                        n_status = ST_EMPTY;
                    end else if (fresh_exhausted) begin
                        n_status = ST_EXHAUSTED;
                    end else begin
                        map_we      = 1'b1;
                        map_wr_addr = r_fresh[HW-1:0];
                        map_wr_data = 1'b1;
                        n_granted   = 8'(r_fresh);
                        n_fresh     = r_fresh + 1'b1;
                    end
                end
                OP_FREE: begin
                    if (rel_in_use && !fq_stat.full) begin
                        map_we       = 1'b1;
                        map_wr_data  = 1'b0;
                        fq_ctrl.push = 1'b1;
                    end else begin
                        n_status = ST_INVALID;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_operation;
            r_rel <= i_release_handle;
        end
        r_granted <= n_granted;
        r_status  <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (map_we) begin
            map_mem[map_wr_addr] <= map_wr_data;
        end
        r_map_rd <= map_mem[map_rd_addr];
    end

    assign o_out_valid      = r_out_valid;
    assign o_granted_handle = r_granted;
    assign o_status         = r_status;

endmodule

// File: rtl/hpa_free_queue.sv
module hpa_free_queue import hpa_pkg::*; #(
    parameter int HANDLES = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_fq_ctrl                   i_ctrl,
    input  logic [$clog2(HANDLES)-1:0] i_push_data,
    output logic [$clog2(HANDLES)-1:0] o_rd_data,
    output t_fq_stat                   o_stat
);

    localparam int HW = $clog2(HANDLES);
    localparam int CW = $clog2(HANDLES + 1);

    logic [HW-1:0] queue_mem [HANDLES];
    logic [HW-1:0] r_rd_data;
    logic [HW-1:0] r_head, n_head;
    logic [HW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_ctrl.pop) begin
            n_head  = (r_head == HW'(HANDLES - 1)) ? '0 : r_head + 1'b1;
            n_count = r_count - 1'b1;
        end
        if (i_ctrl.push) begin
            n_tail  = (r_tail == HW'(HANDLES - 1)) ? '0 : r_tail + 1'b1;
            n_count = r_count + 1'b1;
        end
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(HANDLES));
    assign o_rd_data    = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            queue_mem[r_tail] <= i_push_data;
        end
        r_rd_data <= queue_mem[r_head];
    end

endmodule

// File: rtl/hpa_checker.sv
`include "handle_pool_allocator_unit_macros.svh"

module hpa_checker import hpa_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_granted_handle,
    input logic [1:0] o_status
);

    logic       out_wait;
    logic       out_fail;
    logic       in_take;
    logic [9:0] out_data;

    assign out_wait = o_out_valid && i_out_stall;
    assign out_fail = o_out_valid && (o_status != ST_OK);
    assign in_take  = i_in_valid && !o_in_stall;
    assign out_data = {o_granted_handle, o_status};

    `HPA_ASSERT_NEXT(a_out_valid_hold, out_wait, o_out_valid, "result dropped while stalled")
    `HPA_ASSERT_NEXT(a_out_data_hold, out_wait, $stable(out_data), "stalled result changed")
    `HPA_ASSERT_SAME(a_fail_zero, out_fail, o_granted_handle == '0, "handle given on failure")
    `HPA_ASSERT_NEXT(a_busy_after_accept, in_take, o_in_stall, "transaction accepted while busy")

endmodule

bind handle_pool_allocator_unit hpa_checker u_hpa_checker (.*);

// File: tb/sv/hpa_reply_checker.sv
`timescale 1ns / 100ps

module hpa_reply_checker import hpa_pkg::*; #(
    parameter int HANDLES = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_release_handle,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_granted_handle,
    input  logic [1:0] i_status,
    output int         o_mismatches,
    output int         o_pending
);

    typedef struct packed {
        logic [7:0] handle;
        logic [1:0] status;
    } t_reply;

    logic [HANDLES-1:0] handle_busy;
    logic [7:0]         free_fifo [HANDLES];
    int unsigned        fifo_rd;
    int unsigned        fifo_wr;
    int unsigned        fifo_fill;
    int unsigned        next_fresh;
    t_reply             pending_replies [$];
    int                 mismatch_count = 0;

    task automatic serve_request(input logic [1:0] op, input logic [7:0] rel,
                                 output t_reply reply);
        reply.handle = 8'd0;
        reply.status = ST_OK;
        if (op == OP_ALLOC || op == OP_TRY) begin
            if (fifo_fill > 0) begin
                reply.handle = free_fifo[fifo_rd];
                handle_busy[free_fifo[fifo_rd]] = 1'b1;
                fifo_rd = (fifo_rd + 1) % HANDLES;
                fifo_fill--;
            end else if (op == OP_TRY) begin
                reply.status = ST_EMPTY;
            end else if (next_fresh >= HANDLES) begin
                reply.status = ST_EXHAUSTED;
            end else begin
                reply.handle = 8'(next_fresh);
                handle_busy[next_fresh] = 1'b1;
                next_fresh++;
            end
        end else if (op == OP_FREE) begin
            if (rel >= HANDLES || !handle_busy[rel] || fifo_fill >= HANDLES) begin
                reply.status = ST_INVALID;
            end else begin
                handle_busy[rel] = 1'b0;
                free_fifo[fifo_wr] = rel;
                fifo_wr = (fifo_wr + 1) % HANDLES;
                fifo_fill++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            handle_busy = '0;
            fifo_rd     = 0;
            fifo_wr     = 0;
            fifo_fill   = 0;
            next_fresh  = 0;
            pending_replies.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                serve_request(i_operation, i_release_handle, want);
                pending_replies = {pending_replies, want};
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_replies.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected transaction, handle %0d status %0d",
                             $time, i_granted_handle, i_status);
                end else begin
                    want = pending_replies[0];
                    pending_replies.delete(0);
                    if (want.handle !== i_granted_handle) begin
                        mismatch_count++;
                        $display("%0t: granted_handle expected %0d, actual %0d",
                                 $time, want.handle, i_granted_handle);
                    end
                    if (want.status !== i_status) begin
                        mismatch_count++;
                        $display("%0t: status expected %0d, actual %0d",
                                 $time, want.status, i_status);
                    end
                end
            end
        end
        o_mismatches <= mismatch_count;
        o_pending    <= pending_replies.size();
    end

endmodule

// File: tb/sv/tb_handle_pool_allocator_unit.sv
`timescale 1ns / 100ps

module tb_handle_pool_allocator_unit;
    import hpa_pkg::*;

    localparam int         HANDLES      = 256;
    localparam int         RANDOM_ITEMS = 1350;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    typedef enum int {ROUND_FILL, ROUND_DRAIN, ROUND_MIXED} t_round_kind;
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE, STALL_HOLD}
        t_stall_mode;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] operation;
    logic [7:0] release_handle;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] granted_handle;
    logic [1:0] status;
    int         mismatches;
    int         pending;

    logic [7:0] live_handles [$];
    logic [1:0] accepted_ops [$];
    int         burst_left = 0;

    always #1 clk = ~clk;

    handle_pool_allocator_unit #(.HANDLES(HANDLES)) dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (operation),
        .i_release_handle (release_handle),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_granted_handle (granted_handle),
        .o_status         (status)
    );

    hpa_reply_checker #(.HANDLES(HANDLES)) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_operation      (operation),
        .i_release_handle (release_handle),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_granted_handle (granted_handle),
        .i_status         (status),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    // track handles handed out so most frees name a live handle
    always @(posedge clk) begin
        logic [1:0] served_op;
        if (out_valid && !out_stall && accepted_ops.size() > 0) begin
            served_op = accepted_ops[0];
            accepted_ops.delete(0);
            if ((served_op == OP_ALLOC || served_op == OP_TRY) && status == ST_OK) begin
                live_handles = {live_handles, granted_handle};
            end
        end
        if (rst_n && in_valid && !in_stall) begin
            accepted_ops = {accepted_ops, operation};
        end
    end

    task automatic send(input logic [1:0] op, input logic [7:0] rel);
        if (burst_left == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid       <= 1'b1;
        operation      <= op;
        release_handle <= rel;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic pick_item(input t_round_kind kind, output logic [1:0] op,
                             output logic [7:0] rel);
        int roll;
        int idx;
        logic live_free;
        roll      = $urandom_range(0, 99);
        rel       = 8'($urandom);
        live_free = 1'b0;
        case (kind)
            ROUND_FILL: begin
                if (roll < 2)       op = OP_UNUSED;
                else if (roll < 5)  op = OP_FREE;
                else if (roll < 85) op = OP_ALLOC;
                else                op = OP_TRY;
            end
            ROUND_DRAIN: begin
                if (roll < 85)      live_free = 1'b1;
                else if (roll < 93) op = OP_FREE;
                else if (roll < 97) op = OP_TRY;
                else                op = OP_ALLOC;
            end
            default: begin
                if (roll < 40)      op = OP_ALLOC;
                else if (roll < 52) op = OP_TRY;
                else if (roll < 85) live_free = 1'b1;
                else if (roll < 96) op = OP_FREE;
                else                op = OP_UNUSED;
            end
        endcase
        if (live_free) begin
            op = OP_FREE;
            if (live_handles.size() > 0) begin
                idx = $urandom_range(0, live_handles.size() - 1);
                rel = live_handles[idx];
                live_handles.delete(idx);
            end
        end
    endtask

    initial begin
        int          round_no;
        int          issued;
        int          round_len;
        t_round_kind kind;
        logic [1:0]  op;
        logic [7:0]  rel;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = OP_ALLOC;
        release_handle = 8'd0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send(OP_TRY,    8'hA5);
        send(OP_FREE,   8'd0);
        send(OP_UNUSED, 8'd0);
        send(OP_ALLOC,  8'hFF);
        send(OP_ALLOC,  8'd0);
        send(OP_FREE,   8'd255);
        send(OP_FREE,   8'd1);
        send(OP_FREE,   8'd1);
        send(OP_TRY,    8'd0);
        send(OP_ALLOC,  8'd0);
        send(OP_FREE,   8'd0);
        send(OP_FREE,   8'd2);
        send(OP_ALLOC,  8'd0);
        send(OP_TRY,    8'hFF);
        send(OP_TRY,    8'd0);
        send(OP_UNUSED, 8'hFF);
        send(OP_FREE,   8'd200);
        send(OP_FREE,   8'd0);
        send(OP_FREE,   8'd1);

        issued   = 0;
        round_no = 0;
        while (issued < RANDOM_ITEMS) begin
            case (round_no)
                0:       kind = ROUND_FILL;
                1:       kind = ROUND_DRAIN;
                2:       kind = ROUND_MIXED;
                3:       kind = ROUND_FILL;
                default: kind = t_round_kind'($urandom_range(0, 2));
            endcase
            if (kind == ROUND_FILL)       round_len = 320;
            else if (kind == ROUND_DRAIN) round_len = live_handles.size() + 30;
            else                          round_len = $urandom_range(60, 160);
            for (int k = 0; k < round_len && issued < RANDOM_ITEMS; k++) begin
                pick_item(kind, op, rel);
                send(op, rel);
                issued++;
            end
            round_no++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        int          seg;
        t_stall_mode mode;
        int          span;
        out_stall = 1'b0;
        @(posedge rst_n);
        seg = 0;
        forever begin
            mode = t_stall_mode'($urandom_range(0, 3));
            span = $urandom_range(30, 200);
            // hold off long enough for the block to back up into its input
            if (seg == 3) begin
                mode = STALL_HOLD;
                span = 150;
            end
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    STALL_NONE:   out_stall <= 1'b0;
                    STALL_LIGHT:  out_stall <= ($urandom_range(0, 4) == 0);
                    STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
                    STALL_TOGGLE: out_stall <= ~out_stall;
                    default:      out_stall <= 1'b1;
                endcase
            end
            seg++;
        end
    end

    initial begin
        #400000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/hpa_pkg.sv
rtl/hpa_free_queue.sv
rtl/handle_pool_allocator_unit.sv
rtl/hpa_checker.sv
tb/sv/hpa_reply_checker.sv
tb/sv/tb_handle_pool_allocator_unit.sv
